// ----- sv/ptq_pkg.sv -----
// Package for the preemptive priority task queue.
// Holds the shared types, operation codes and status codes; depends on nothing.
package ptq_pkg;

   localparam int unsigned ID_W    = 8;
   localparam int unsigned PRI_W   = 8;
   localparam int unsigned LEVEL_W = 9;

   localparam logic [LEVEL_W-1:0] IDLE_LEVEL = 9'd256;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_DISPATCH = 2'd1;
   localparam logic [1:0] OP_COMPLETE = 2'd2;

   typedef enum logic [2:0] {
      ST_ADDED      = 3'd0,
      ST_DISPATCHED = 3'd1,
      ST_NONE       = 3'd2,
      ST_FULL       = 3'd3,
      ST_DONE       = 3'd4,
      ST_NEST_ERR   = 3'd5
   } status_type;

   // One queue slot as seen by its neighbors.
   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
   } qentry_type;

   // Broadcast control from the top level to every queue cell.
   typedef struct packed {
      logic             insert;
      logic             remove;
      logic [ID_W-1:0]  new_id;
      logic [PRI_W-1:0] new_pri;
   } qctl_type;

   // Broadcast control to every nesting stack cell.
   typedef struct packed {
      logic push;
      logic pop;
   } sctl_type;

endpackage

// ----- sv/ptq_if.sv -----
// Valid/ready channel interfaces for the task queue request and response.
// Depends on ptq_pkg for the field widths.
interface ptq_req_if import ptq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic [ID_W-1:0]  task_id;
   logic [PRI_W-1:0] priority_req;

   modport source (output valid, output op, output task_id, output priority_req,
                   input ready);
   modport sink   (input valid, input op, input task_id, input priority_req,
                   output ready);
endinterface

interface ptq_rsp_if import ptq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [ID_W-1:0]    out_task_id;
   logic [PRI_W-1:0]   out_priority;
   logic [LEVEL_W-1:0] running_priority;

   modport source (output valid, output status, output out_task_id,
                   output out_priority, output running_priority, input ready);
   modport sink   (input valid, input status, input out_task_id,
                   input out_priority, input running_priority, output ready);
endinterface

// ----- sv/ptq_qcell.sv -----
// One slot of the sorted task queue: holds an entry and shifts with its neighbors.
// Depends on ptq_pkg.
module ptq_qcell import ptq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  qctl_type   ctl,
   input  qentry_type left_entry,
   input  logic       left_keep,
   input  qentry_type right_entry,
   output qentry_type entry,
   output logic       keep
);

   logic             valid_ff, valid_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [PRI_W-1:0] pri_ff, pri_in;

   // This slot stays ahead of a new task of equal or higher number.
   assign keep  = valid_ff && (pri_ff <= ctl.new_pri);
   assign entry = '{valid: valid_ff, id: id_ff, pri: pri_ff};

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      pri_in   = pri_ff;
      priority if (ctl.remove) begin
         valid_in = right_entry.valid;
         id_in    = right_entry.id;
         pri_in   = right_entry.pri;
      end else if (ctl.insert && !keep) begin
         if (left_keep) begin
            valid_in = 1'b1;
            id_in    = ctl.new_id;
            pri_in   = ctl.new_pri;
         end else begin
            valid_in = left_entry.valid;
            id_in    = left_entry.id;
            pri_in   = left_entry.pri;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff  <= id_in;
      pri_ff <= pri_in;
   end

endmodule

// ----- sv/ptq_scell.sv -----
// One slot of the nesting stack of saved running priorities.
// Depends on ptq_pkg.
module ptq_scell import ptq_pkg::*; (
   input  logic               clock,
   input  sctl_type           ctl,
   input  logic [LEVEL_W-1:0] left_level,
   input  logic [LEVEL_W-1:0] right_level,
   output logic [LEVEL_W-1:0] level
);

   logic [LEVEL_W-1:0] level_ff, level_in;

   assign level = level_ff;

   always_comb begin
      level_in = level_ff;
      priority if (ctl.push) begin
         level_in = left_level;
      end else if (ctl.pop) begin
         level_in = right_level;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

endmodule

// ----- sv/preemptive_priority_task_queue_unit.sv -----
// Preemptive priority task queue, top level.
// Latency: a request's response appears in the cycle after it is accepted.
// Throughput: one request per cycle unless rsp_if stalls; each row shifts at most once.
// Reset (synchronous, active high) empties the queue, clears the nesting depth
// and sets the running priority to idle (256); slot contents are not cleared.
// Depends on ptq_pkg, ptq_if, ptq_qcell and ptq_scell.
module preemptive_priority_task_queue_unit import ptq_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned NEST_DEPTH  = 8
) (
   input  logic      clock,
   input  logic      reset,
   ptq_req_if.sink   req_if,
   ptq_rsp_if.source rsp_if
);

   localparam int unsigned NPTR_W = $clog2(NEST_DEPTH + 1);

   // The queue is a row of cells kept sorted by priority number, head at
   // slot 0. An add broadcasts the new task; each cell decides locally
   // whether to hold, take the new task, or take its left neighbor, so the
   // whole row shifts right behind the insertion point. A dispatch shifts
   // the whole row left by one.
   qentry_type q_entry [QUEUE_DEPTH];
   logic       q_keep  [QUEUE_DEPTH];
   qctl_type   q_ctl;

   // The nesting stack is a second row of cells with the top at slot 0; a
   // push shifts right with the running priority entering slot 0, a pop
   // shifts left.
   logic [LEVEL_W-1:0] s_level [NEST_DEPTH];
   sctl_type           s_ctl;

   logic [NPTR_W-1:0]  nest_ptr_ff, nest_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [PRI_W-1:0]   rsp_pri_ff, rsp_pri_in;
   logic [LEVEL_W-1:0] rsp_level_ff;

   logic accept;
   logic q_full;
   logic eligible;
   logic nest_full;
   logic nest_empty;

   genvar k;
   generate
      for (k = 0; k < QUEUE_DEPTH; k++) begin : g_q
         qentry_type left_e, right_e;
         logic       left_k;
         if (k == 0) begin : g_first
            assign left_e = '0;
            assign left_k = 1'b1;
         end else begin : g_mid
            assign left_e = q_entry[k-1];
            assign left_k = q_keep[k-1];
         end
         if (k == QUEUE_DEPTH - 1) begin : g_last
            assign right_e = '0;
         end else begin : g_inner
            assign right_e = q_entry[k+1];
         end
         ptq_qcell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (q_ctl),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .entry       (q_entry[k]),
            .keep        (q_keep[k])
         );
      end

      for (k = 0; k < NEST_DEPTH; k++) begin : g_s
         logic [LEVEL_W-1:0] left_l, right_l;
         if (k == 0) begin : g_first
            assign left_l = level_ff;
         end else begin : g_mid
            assign left_l = s_level[k-1];
         end
         if (k == NEST_DEPTH - 1) begin : g_last
            assign right_l = '0;
         end else begin : g_inner
            assign right_l = s_level[k+1];
         end
         ptq_scell u_cell (
            .clock       (clock),
            .ctl         (s_ctl),
            .left_level  (left_l),
            .right_level (right_l),
            .level       (s_level[k])
         );
      end
   endgenerate

   // A new request is taken whenever the response register is empty or is
   // being drained in this same cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // The queue is full exactly when its last slot is occupied, since the
   // occupied slots always form a prefix of the row.
   assign q_full     = q_entry[QUEUE_DEPTH-1].valid;
   // The head runs only if its number is strictly below the running priority.
   assign eligible   = q_entry[0].valid && ({1'b0, q_entry[0].pri} < level_ff);
   assign nest_full  = (nest_ptr_ff == NPTR_W'(NEST_DEPTH));
   assign nest_empty = (nest_ptr_ff == '0);

   always_comb begin
      q_ctl.insert  = 1'b0;
      q_ctl.remove  = 1'b0;
      q_ctl.new_id  = req_if.task_id;
      q_ctl.new_pri = req_if.priority_req;
      s_ctl.push    = 1'b0;
      s_ctl.pop     = 1'b0;
      nest_ptr_in   = nest_ptr_ff;
      level_in      = level_ff;
      rsp_status_in = ST_NONE;
      rsp_id_in     = '0;
      rsp_pri_in    = '0;
      if (accept) begin
         unique case (req_if.op)
            OP_ADD: begin
               if (q_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  q_ctl.insert  = 1'b1;
                  rsp_status_in = ST_ADDED;
               end
            end
            OP_DISPATCH: begin
               // An ineligible head is reported as none even when the stack
               // is full; the overflow only blocks a grant.
               if (!eligible) begin
                  rsp_status_in = ST_NONE;
               end else if (nest_full) begin
                  rsp_status_in = ST_NEST_ERR;
               end else begin
                  q_ctl.remove  = 1'b1;
                  s_ctl.push    = 1'b1;
                  nest_ptr_in   = nest_ptr_ff + 1'b1;
                  level_in      = {1'b0, q_entry[0].pri};
                  rsp_status_in = ST_DISPATCHED;
                  rsp_id_in     = q_entry[0].id;
                  rsp_pri_in    = q_entry[0].pri;
               end
            end
            OP_COMPLETE: begin
               if (nest_empty) begin
                  rsp_status_in = ST_NEST_ERR;
               end else begin
                  s_ctl.pop     = 1'b1;
                  nest_ptr_in   = nest_ptr_ff - 1'b1;
                  level_in      = s_level[0];
                  rsp_status_in = ST_DONE;
               end
            end
            default: begin
               rsp_status_in = ST_NONE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nest_ptr_ff  <= '0;
         level_ff     <= IDLE_LEVEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         nest_ptr_ff  <= nest_ptr_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_pri_ff    <= rsp_pri_in;
         rsp_level_ff  <= level_in;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.status           = rsp_status_ff;
   assign rsp_if.out_task_id      = rsp_id_ff;
   assign rsp_if.out_priority     = rsp_pri_ff;
   assign rsp_if.running_priority = rsp_level_ff;

   // Occupied queue slots form a prefix of the row.
   a_q_prefix: assert property (@(posedge clock) disable iff (reset)
      q_entry[1].valid |-> q_entry[0].valid)
      else $error("queue slot 1 occupied while head slot is empty");

   // The head is never less urgent than the slot behind it.
   a_q_sorted: assert property (@(posedge clock) disable iff (reset)
      q_entry[1].valid |-> (q_entry[0].pri <= q_entry[1].pri))
      else $error("queue head out of priority order");

   // The nesting depth never exceeds the stack size.
   a_nest_range: assert property (@(posedge clock) disable iff (reset)
      nest_ptr_ff <= NPTR_W'(NEST_DEPTH))
      else $error("nesting depth beyond stack size");

   // With nothing nested, the running priority is idle.
   a_idle_level: assert property (@(posedge clock) disable iff (reset)
      nest_empty |-> (level_ff == IDLE_LEVEL))
      else $error("running priority not idle with empty nesting stack");

   // A granted dispatch makes the task's number the running priority.
   a_dispatch_level: assert property (@(posedge clock) disable iff (reset)
      (accept && (rsp_status_in == ST_DISPATCHED)) |=>
         (rsp_level_ff == {1'b0, rsp_pri_ff}))
      else $error("dispatched priority differs from running priority");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for preemptive_priority_task_queue_unit: directed and random requests, scored
// against a behavioral model of the sorted queue and the nesting stack kept in this file.
// Depends on ptq_pkg, ptq_if and the RTL of the task queue.
module tb import ptq_pkg::*; ();

   localparam int QUEUE_SLOTS = 16;
   localparam int NEST_SLOTS  = 8;
   // Op code 3 has no meaning; the block answers it like a refused dispatch.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 90;
   localparam int MAX_REPORTS = 10;

   // One expected response, field by field.
   typedef struct {
      status_type         status;
      logic [ID_W-1:0]    task_id;
      logic [PRI_W-1:0]   pri;
      logic [LEVEL_W-1:0] level;
   } task_outcome_type;

   logic clock = 1'b0;
   logic reset;

   ptq_req_if req_ch ();
   ptq_rsp_if rsp_ch ();

   preemptive_priority_task_queue_unit #(
      .QUEUE_DEPTH (QUEUE_SLOTS),
      .NEST_DEPTH  (NEST_SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #6 clock = ~clock;

   // Model state: the sorted queue of deferred tasks, the running priority and the
   // stack of priorities that were preempted.
   logic [ID_W-1:0]    slot_ids  [QUEUE_SLOTS];
   logic [PRI_W-1:0]   slot_pris [QUEUE_SLOTS];
   int                 slot_count = 0;
   logic [LEVEL_W-1:0] run_level = IDLE_LEVEL;
   logic [LEVEL_W-1:0] preempted_levels [NEST_SLOTS];
   int                 nest_depth = 0;

   task_outcome_type pending_outcomes[$];

   int  mismatches = 0;
   int  requests_sent = 0;
   int  status_tally [8];
   bit  send_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;
   bit  hold_start = 1'b0;
   int  hold_left = 0;
   int  longest_hold = 0;

   // Applies one request to the model and returns the response the block must give.
   function automatic task_outcome_type predict_outcome(input logic [1:0] op,
                                                        input logic [ID_W-1:0] id,
                                                        input logic [PRI_W-1:0] pri);
      task_outcome_type o;
      int pos;
      int k;
      o.status  = ST_NONE;
      o.task_id = '0;
      o.pri     = '0;
      case (op)
         OP_ADD: begin
            if (slot_count >= QUEUE_SLOTS) begin
               o.status = ST_FULL;
            end else begin
               // A new task goes behind every task of equal or lower number.
               pos = 0;
               while (pos < slot_count && slot_pris[pos] <= pri) pos++;
               for (k = slot_count; k > pos; k--) begin
                  slot_ids[k]  = slot_ids[k-1];
                  slot_pris[k] = slot_pris[k-1];
               end
               slot_ids[pos]  = id;
               slot_pris[pos] = pri;
               slot_count++;
               o.status = ST_ADDED;
            end
         end
         OP_DISPATCH: begin
            // Only a head task strictly more urgent than the running one is eligible.
            if (slot_count != 0 && {1'b0, slot_pris[0]} < run_level) begin
               if (nest_depth >= NEST_SLOTS) begin
                  o.status = ST_NEST_ERR;
               end else begin
                  preempted_levels[nest_depth] = run_level;
                  nest_depth++;
                  run_level = {1'b0, slot_pris[0]};
                  o.status  = ST_DISPATCHED;
                  o.task_id = slot_ids[0];
                  o.pri     = slot_pris[0];
                  for (k = 1; k < slot_count; k++) begin
                     slot_ids[k-1]  = slot_ids[k];
                     slot_pris[k-1] = slot_pris[k];
                  end
                  slot_count--;
               end
            end
         end
         OP_COMPLETE: begin
            if (nest_depth == 0) begin
               o.status = ST_NEST_ERR;
            end else begin
               nest_depth--;
               run_level = preempted_levels[nest_depth];
               o.status  = ST_DONE;
            end
         end
         default: o.status = ST_NONE;
      endcase
      o.level = run_level;
      return o;
   endfunction

   // Offers one request, possibly after a few idle cycles, and waits until it is taken.
   // Valid stays high afterwards so that back-to-back requests need no gap.
   task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] id,
                               input logic [PRI_W-1:0] pri);
      task_outcome_type o;
      while (send_gaps_on && $urandom_range(99) < 31) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.task_id      <= id;
      req_ch.priority_req <= pri;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      o = predict_outcome(op, id, pri);
      pending_outcomes.push_back(o);
      status_tally[o.status]++;
      requests_sent++;
   endtask

   // Stops offering and waits until every outstanding response has come back.
   task automatic wait_for_outcomes();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Brings the block back to idle with an empty queue, using only legal requests.
   task automatic clear_block();
      while (nest_depth != 0)
         send_request(OP_COMPLETE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      // At idle level every queued task is eligible, so dispatch and finish each one.
      while (slot_count != 0) begin
         send_request(OP_DISPATCH, 8'($urandom_range(255)), 8'($urandom_range(255)));
         send_request(OP_COMPLETE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
   endtask

   // Field extremes, ties, eligibility edges, unused op code and stack underflow.
   task automatic test_directed();
      send_request(OP_UNUSED, 8'hFF, 8'hFF);
      send_request(OP_COMPLETE, 8'h00, 8'h00);   // nothing is running yet
      send_request(OP_DISPATCH, 8'hFF, 8'hFF);   // empty queue
      send_request(OP_ADD, 8'hFF, 8'hFF);
      send_request(OP_ADD, 8'h00, 8'h00);
      send_request(OP_ADD, 8'h5A, 8'h00);        // ties with the task before it
      send_request(OP_DISPATCH, 8'h00, 8'h00);
      send_request(OP_DISPATCH, 8'hA5, 8'hA5);   // head equals running priority
      send_request(OP_UNUSED, 8'h00, 8'h00);
      send_request(OP_COMPLETE, 8'hFF, 8'hFF);
      send_request(OP_DISPATCH, 8'h00, 8'h00);   // the tied task leaves second
      send_request(OP_COMPLETE, 8'h00, 8'h00);
      send_request(OP_DISPATCH, 8'h00, 8'h00);   // number 255 still runs from idle
      send_request(OP_ADD, 8'hC3, 8'hFF);
      send_request(OP_DISPATCH, 8'h00, 8'h00);
      send_request(OP_COMPLETE, 8'h00, 8'h00);
      send_request(OP_COMPLETE, 8'h00, 8'h00);
      send_request(OP_DISPATCH, 8'h3C, 8'h3C);
      send_request(OP_COMPLETE, 8'h00, 8'h00);
   endtask

   // Fills the queue to the brim, overfills it, then empties it in priority order.
   task automatic test_queue_full();
      int base;
      int spread;
      repeat (3) begin
         clear_block();
         base   = $urandom_range(255);
         spread = $urandom_range(1) ? 3 : 255;
         while (slot_count < QUEUE_SLOTS)
            send_request(OP_ADD, 8'($urandom_range(255)), 8'(base + $urandom_range(spread)));
         repeat (2)
            send_request(OP_ADD, 8'($urandom_range(255)), 8'($urandom_range(255)));
         send_request(OP_DISPATCH, 8'($urandom_range(255)), 8'($urandom_range(255)));
         send_request(OP_ADD, 8'($urandom_range(255)), 8'($urandom_range(255)));
         send_request(OP_ADD, 8'($urandom_range(255)), 8'($urandom_range(255)));
         clear_block();
      end
   endtask

   // Nests dispatches until the stack is full, tries one more, then unwinds past
   // the bottom of the stack.
   task automatic test_nesting_limit();
      int pri;
      repeat (3) begin
         clear_block();
         pri = $urandom_range(200, 255);
         repeat (NEST_SLOTS) begin
            send_request(OP_ADD, 8'($urandom_range(255)), 8'(pri));
            if ($urandom_range(1)) send_request(OP_ADD, 8'($urandom_range(255)), 8'hFF);
            send_request(OP_DISPATCH, 8'($urandom_range(255)), 8'($urandom_range(255)));
            pri -= $urandom_range(1, 20);
         end
         send_request(OP_ADD, 8'($urandom_range(255)), 8'(pri));
         send_request(OP_DISPATCH, 8'($urandom_range(255)), 8'($urandom_range(255)));
         send_request(OP_DISPATCH, 8'($urandom_range(255)), 8'($urandom_range(255)));
         repeat (NEST_SLOTS + 1)
            send_request(OP_COMPLETE, 8'($urandom_range(255)), 8'($urandom_range(255)));
         clear_block();
      end
   endtask

   // Random traffic in phases: some favor adds, some favor removals, some build
   // preemption chains, and some are plain noise over every field.
   task automatic run_mix(input int count);
      int left;
      int phase_len;
      int kind;
      int roll;
      int base;
      int below;
      logic [1:0] op;
      logic [PRI_W-1:0] pri;
      left = count;
      while (left > 0) begin
         phase_len = $urandom_range(10, 60);
         kind      = $urandom_range(3);
         base      = $urandom_range(255);
         while (phase_len > 0 && left > 0) begin
            roll = $urandom_range(99);
            pri  = $urandom_range(1) ? 8'($urandom_range(255)) : 8'(base + $urandom_range(7));
            case (kind)
               0: op = roll < 60 ? OP_ADD : roll < 80 ? OP_DISPATCH :
                       roll < 95 ? OP_COMPLETE : OP_UNUSED;
               1: op = roll < 15 ? OP_ADD : roll < 55 ? OP_DISPATCH :
                       roll < 95 ? OP_COMPLETE : OP_UNUSED;
               2: begin
                  // Each added task just outranks the running one, so dispatches nest.
                  if (run_level == 0 || (nest_depth == NEST_SLOTS && roll < 60)) begin
                     op = OP_COMPLETE;
                  end else if (roll < 50) begin
                     op    = OP_ADD;
                     below = int'(run_level) - $urandom_range(1, 16);
                     pri   = below < 0 ? 8'd0 : 8'(below);
                  end else begin
                     op = OP_DISPATCH;
                  end
               end
               default: op = 2'($urandom_range(3));
            endcase
            send_request(op, 8'($urandom_range(255)), pri);
            phase_len--;
            left--;
         end
      end
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the block
   // must stall its input; afterwards the sender waits for every response.
   task automatic test_backpressure();
      hold_start = 1'b1;
      run_mix(60);
      wait_for_outcomes();
      run_mix(40);
      wait_for_outcomes();
   endtask

   // A long stretch in which neither side ever idles.
   task automatic test_full_rate();
      send_gaps_on = 1'b0;
      rsp_gaps_on  = 1'b0;
      run_mix(250);
      send_gaps_on = 1'b1;
      rsp_gaps_on  = 1'b1;
   endtask

   // Response side: random stalls, plus the long hold-off that the test asks for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            longest_hold++;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(rsp_gaps_on && $urandom_range(99) < 31);
         end
      end
   end

   // Every response taken is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      task_outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected response: status %0d id %0d pri %0d level %0d",
                        $realtime, rsp_ch.status, rsp_ch.out_task_id, rsp_ch.out_priority,
                        rsp_ch.running_priority);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.out_task_id !== want.task_id ||
                rsp_ch.out_priority !== want.pri || rsp_ch.running_priority !== want.level) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"%0t: mismatch: expected status %0d id %0d pri %0d level %0d,",
                            " got status %0d id %0d pri %0d level %0d"},
                           $realtime, want.status, want.task_id, want.pri, want.level,
                           rsp_ch.status, rsp_ch.out_task_id, rsp_ch.out_priority,
                           rsp_ch.running_priority);
            end
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.op           <= OP_ADD;
      req_ch.task_id      <= '0;
      req_ch.priority_req <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_queue_full();
      test_nesting_limit();
      test_backpressure();
      run_mix(700);
      test_full_rate();
      run_mix(350);

      wait_for_outcomes();
      repeat (5) @(posedge clock);
      $display("tb: %0d requests: %0d added, %0d dispatched, %0d refused, %0d queue full",
               requests_sent, status_tally[ST_ADDED], status_tally[ST_DISPATCHED],
               status_tally[ST_NONE], status_tally[ST_FULL]);
      $display("tb: %0d completions, %0d nesting errors, %0d held cycles, %0d mismatches",
               status_tally[ST_DONE], status_tally[ST_NEST_ERR], longest_hold, mismatches);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Safety net: the run needs well under a tenth of this.
   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
